@@ rtl/core/ipv4rt_pkg.sv @@
// Package for the IPv4 route table: sizes, request and status codes,
// payload structs and the controller/datapath command interface.
// No dependencies.
package ipv4rt_pkg;

	localparam int TABLE_DEPTH    = 64;
	localparam int MAX_HOPS       = 4;
	localparam int NUM_LOCAL_ADDR = 4;

	localparam int TAW    = $clog2(TABLE_DEPTH);
	localparam int HW     = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
	localparam int HOP_AW = $clog2(TABLE_DEPTH * MAX_HOPS);

	localparam logic [2:0] RQ_ADD  = 3'd0;
	localparam logic [2:0] RQ_DEL  = 3'd1;
	localparam logic [2:0] RQ_CLR  = 3'd2;
	localparam logic [2:0] RQ_FWD  = 3'd3;
	localparam logic [2:0] RQ_ORIG = 3'd4;

	localparam logic [3:0] ST_NEW_ROUTE = 4'd0;
	localparam logic [3:0] ST_HOP_ADDED = 4'd1;
	localparam logic [3:0] ST_NO_CHANGE = 4'd2;
	localparam logic [3:0] ST_DUPLICATE = 4'd3;
	localparam logic [3:0] ST_HOPS_FULL = 4'd4;
	localparam logic [3:0] ST_TBL_FULL  = 4'd5;
	localparam logic [3:0] ST_DELETED   = 4'd6;
	localparam logic [3:0] ST_NOT_FOUND = 4'd7;
	localparam logic [3:0] ST_CLEARED   = 4'd8;
	localparam logic [3:0] ST_NO_ROUTE  = 4'd9;
	localparam logic [3:0] ST_LOCAL     = 4'd10;
	localparam logic [3:0] ST_DIRECT    = 4'd11;
	localparam logic [3:0] ST_GATEWAY   = 4'd12;
	localparam logic [3:0] ST_TTL_EXP   = 4'd13;

	localparam logic [2:0] REG_LOOPBACK = 3'd0;
	localparam logic [2:0] REG_LOCAL0   = 3'd1;
	localparam logic [2:0] REG_LOCAL1   = 3'd2;
	localparam logic [2:0] REG_LOCAL2   = 3'd3;
	localparam logic [2:0] REG_LOCAL3   = 3'd4;
	localparam logic [2:0] REG_LOC_EN   = 3'd5;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] dest_addr;
		logic [5:0]  prefix_len;
		logic        has_gateway;
		logic [31:0] gateway_addr;
		logic [3:0]  gateway_port;
		logic [31:0] cost_in;
		logic [7:0]  ttl_in;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] next_hop_addr;
		logic [3:0]  out_port;
		logic [7:0]  ttl_out;
		logic [31:0] route_cost;
	} rsp_t;

	typedef struct packed {
		logic [31:0]      prefix;
		logic [5:0]       len;
		logic             direct;
		logic [31:0]      cost;
		logic [HW-1:0]    rot;
	} ent_t;

	typedef struct packed {
		logic        present;
		logic [31:0] gw;
		logic [3:0]  port;
	} hop_t;

	typedef struct packed {
		logic [31:0]      loopback;
		logic [3:0][31:0] local_addr;
		logic [3:0]       local_en;
	} cfg_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_SCAN, CMD_DECIDE, CMD_HOP_CHK, CMD_HOP_WR,
		CMD_NEW, CMD_INIT, CMD_RR_CHK0, CMD_RR_CHK1, CMD_RR_WB, CMD_RESULT
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_HOP_RD, S_HOP_CHK, S_HOP_WR, S_NEW, S_INIT,
		S_RR_RD0, S_RR_CHK0, S_RR_RD1, S_RR_CHK1, S_RR_WB, S_FIN
	} state_t;

	typedef struct packed {
		logic scan_done;
		logic need_hop;
		logic need_new;
		logic need_rr;
		logic hop_free;
		logic hop_dup;
		logic hop_last;
		logic rr_retry;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] len_mask(input logic [5:0] len);
		if (len == 6'd0)
			return 32'h0;
		return 32'hFFFF_FFFF << (6'd32 - len);
	endfunction

endpackage

@@ rtl/core/ipv4rt_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ipv4rt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/ipv4rt_ctrl.sv @@
// Controller state machine for the route table: sequences scan, hop
// handling and result hand-off. Depends on ipv4rt_pkg.
module ipv4rt_ctrl import ipv4rt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  busy,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:    if (req_valid) state_nx = S_SCAN;
			S_SCAN:    if (stat.scan_done) state_nx = S_DECIDE;
			S_DECIDE: begin
				if (stat.need_hop)
					state_nx = S_HOP_RD;
				else if (stat.need_new)
					state_nx = S_NEW;
				else if (stat.need_rr)
					state_nx = S_RR_RD0;
				else
					state_nx = S_FIN;
			end
			S_HOP_RD:  state_nx = S_HOP_CHK;
			S_HOP_CHK: begin
				if (stat.hop_free)
					state_nx = S_HOP_WR;
				else if (stat.hop_dup || stat.hop_last)
					state_nx = S_FIN;
				else
					state_nx = S_HOP_RD;
			end
			S_HOP_WR:  state_nx = S_FIN;
			S_NEW:     state_nx = S_INIT;
			S_INIT:    if (stat.hop_last) state_nx = S_FIN;
			S_RR_RD0:  state_nx = S_RR_CHK0;
			S_RR_CHK0: begin
				if (stat.rr_retry)
					state_nx = S_RR_RD0;
				else if (stat.hop_last)
					state_nx = S_RR_WB;
				else
					state_nx = S_RR_RD1;
			end
			S_RR_RD1:  state_nx = S_RR_CHK1;
			S_RR_CHK1: state_nx = S_RR_WB;
			S_RR_WB:   state_nx = S_FIN;
			S_FIN:     if (stat.out_free) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = CMD_NONE;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:    if (req_valid) cmd = CMD_LOAD;
			S_SCAN:    cmd = CMD_SCAN;
			S_DECIDE:  cmd = CMD_DECIDE;
			S_HOP_CHK: cmd = CMD_HOP_CHK;
			S_HOP_WR:  cmd = CMD_HOP_WR;
			S_NEW:     cmd = CMD_NEW;
			S_INIT:    cmd = CMD_INIT;
			S_RR_CHK0: cmd = CMD_RR_CHK0;
			S_RR_CHK1: cmd = CMD_RR_CHK1;
			S_RR_WB:   cmd = CMD_RR_WB;
			S_FIN:     if (stat.out_free) cmd = CMD_RESULT;
			default:   cmd = CMD_NONE;
		endcase
	end

endmodule

@@ rtl/core/ipv4rt_dp.sv @@
// Datapath for the route table: entry and hop RAMs, valid bits, scan
// match logic, result and output registers. Depends on ipv4rt_pkg, ipv4rt_ram.
module ipv4rt_dp import ipv4rt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output stat_t stat,
	input  req_t  req,
	input  cfg_t  cfg,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	localparam int ENT_W = $bits(ent_t);
	localparam int HOP_W = $bits(hop_t);

	req_t              req_q;
	logic [5:0]        plen_q;
	logic [31:0]       pfx_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [TAW:0]      scan_ptr_q;
	logic              rd_v_s1;
	logic [TAW-1:0]    idx_s1;

	logic              exact_hit_q, free_hit_q, best_hit_q, dflt_hit_q;
	logic [TAW-1:0]    exact_idx_q, free_idx_q, best_idx_q, dflt_idx_q;
	ent_t              exact_word_q, best_word_q, dflt_word_q;
	logic [5:0]        longest_q;

	logic [TAW-1:0]    sel_idx_q;
	ent_t              sel_word_q;
	logic [HW-1:0]     hop_i_q;
	rsp_t              res_q;

	logic [ENT_W-1:0]  ent_rdata, ent_wdata;
	logic              ent_we;
	logic [HOP_W-1:0]  hop_rdata, hop_wdata;
	logic              hop_we;
	logic [HOP_AW-1:0] hop_addr;
	ent_t              e_rd;
	hop_t              h_rd;
	logic              v_rd, is_fwd, is_local, ttl_low, lhit;
	ent_t              lword;
	logic [TAW-1:0]    lidx;
	logic [HW-1:0]     rot_start;

	ipv4rt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(sel_idx_q), .wdata(ent_wdata),
		.raddr(scan_ptr_q[TAW-1:0]), .rdata(ent_rdata)
	);

	ipv4rt_ram #(.WIDTH(HOP_W), .DEPTH(TABLE_DEPTH * MAX_HOPS)) u_hop_ram (
		.clk(clk), .we(hop_we), .waddr(hop_addr), .wdata(hop_wdata),
		.raddr(hop_addr), .rdata(hop_rdata)
	);

	assign e_rd     = ent_t'(ent_rdata);
	assign h_rd     = hop_t'(hop_rdata);
	assign v_rd     = valid_q[idx_s1];
	assign hop_addr = HOP_AW'(sel_idx_q) * HOP_AW'(MAX_HOPS) + HOP_AW'(hop_i_q);
	assign is_fwd   = (req_q.req_type == RQ_FWD);
	assign ttl_low  = (req_q.ttl_in <= 8'd1);
	assign lhit     = best_hit_q || dflt_hit_q;
	assign lword    = best_hit_q ? best_word_q : dflt_word_q;
	assign lidx     = best_hit_q ? best_idx_q : dflt_idx_q;
	assign rot_start = ((HW+1)'(lword.rot) >= (HW+1)'(MAX_HOPS)) ? '0 : lword.rot;

	always_comb begin
		is_local = (req_q.dest_addr == cfg.loopback);
		for (int i = 0; i < NUM_LOCAL_ADDR; i++)
			if (cfg.local_en[i] && cfg.local_addr[i] == req_q.dest_addr)
				is_local = 1'b1;
	end

	// RAM write ports
	always_comb begin
		ent_we    = 1'b0;
		ent_wdata = sel_word_q;
		hop_we    = 1'b0;
		hop_wdata = {1'b1, req_q.gateway_addr, req_q.gateway_port};
		case (cmd)
			CMD_HOP_WR: begin
				ent_we = 1'b1;
				ent_wdata = {sel_word_q.prefix, sel_word_q.len, 1'b0, req_q.cost_in,
					sel_word_q.rot};
				hop_we = 1'b1;
			end
			CMD_NEW: begin
				ent_we = 1'b1;
				ent_wdata = {pfx_q, plen_q, !req_q.has_gateway,
					req_q.has_gateway ? req_q.cost_in : 32'h0, {HW{1'b0}}};
			end
			CMD_INIT: begin
				hop_we = 1'b1;
				if (!(hop_i_q == '0 && req_q.has_gateway))
					hop_wdata = '0;
			end
			CMD_RR_WB: begin
				ent_we = 1'b1;
				ent_wdata = {sel_word_q.prefix, sel_word_q.len, sel_word_q.direct,
					sel_word_q.cost, hop_i_q};
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.scan_done = rd_v_s1 && (idx_s1 == TAW'(TABLE_DEPTH - 1));
		stat.need_hop  = (req_q.req_type == RQ_ADD) && exact_hit_q && req_q.has_gateway;
		stat.need_new  = (req_q.req_type == RQ_ADD) && !exact_hit_q && free_hit_q;
		stat.need_rr   = (is_fwd || req_q.req_type == RQ_ORIG) && lhit && !lword.direct
			&& !(is_fwd && ttl_low);
		stat.hop_free  = !h_rd.present;
		stat.hop_dup   = h_rd.present && h_rd.gw == req_q.gateway_addr
			&& h_rd.port == req_q.gateway_port;
		stat.hop_last  = (hop_i_q == HW'(MAX_HOPS - 1));
		stat.rr_retry  = !h_rd.present && (hop_i_q != '0);
		stat.out_free  = !rsp_valid || !rsp_stall;
	end

	// control state: valid bits, scan pipe, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			scan_ptr_q <= '0;
			rd_v_s1    <= 1'b0;
			rsp_valid  <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			case (cmd)
				CMD_LOAD: scan_ptr_q <= '0;
				CMD_SCAN: begin
					if (scan_ptr_q < (TAW+1)'(TABLE_DEPTH)) begin
						rd_v_s1    <= 1'b1;
						scan_ptr_q <= scan_ptr_q + 1'b1;
					end
					if (rd_v_s1 && v_rd && req_q.req_type == RQ_CLR && !e_rd.direct)
						valid_q[idx_s1] <= 1'b0;
				end
				CMD_DECIDE:
					if (req_q.req_type == RQ_DEL && exact_hit_q)
						valid_q[exact_idx_q] <= 1'b0;
				CMD_NEW: valid_q[sel_idx_q] <= 1'b1;
				default: ;
			endcase
			if (cmd == CMD_RESULT)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_ptr_q[TAW-1:0];
		if (cmd == CMD_RESULT)
			rsp <= res_q;
		case (cmd)
			CMD_LOAD: begin
				req_q       <= req;
				plen_q      <= (req.prefix_len > 6'd32) ? 6'd32 : req.prefix_len;
				pfx_q       <= req.dest_addr &
					len_mask((req.prefix_len > 6'd32) ? 6'd32 : req.prefix_len);
				exact_hit_q <= 1'b0;
				free_hit_q  <= 1'b0;
				best_hit_q  <= 1'b0;
				dflt_hit_q  <= 1'b0;
				longest_q   <= '0;
				res_q       <= {ST_NO_CHANGE, 32'h0, 4'h0, req.ttl_in, 32'h0};
			end
			CMD_SCAN: if (rd_v_s1) begin
				if (v_rd && !exact_hit_q && e_rd.prefix == pfx_q && e_rd.len == plen_q) begin
					exact_hit_q  <= 1'b1;
					exact_idx_q  <= idx_s1;
					exact_word_q <= e_rd;
				end
				if (!v_rd && !free_hit_q) begin
					free_hit_q <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (v_rd) begin
					if (e_rd.prefix == 32'h0 && e_rd.len == 6'd0) begin
						dflt_hit_q  <= 1'b1;
						dflt_idx_q  <= idx_s1;
						dflt_word_q <= e_rd;
					end else if ((req_q.dest_addr & len_mask(e_rd.len)) == e_rd.prefix
							&& e_rd.len > longest_q) begin
						longest_q   <= e_rd.len;
						best_hit_q  <= 1'b1;
						best_idx_q  <= idx_s1;
						best_word_q <= e_rd;
					end
				end
			end
			CMD_DECIDE: begin
				hop_i_q <= '0;
				case (req_q.req_type)
					RQ_ADD: begin
						if (exact_hit_q) begin
							sel_idx_q        <= exact_idx_q;
							sel_word_q       <= exact_word_q;
							res_q.route_cost <= exact_word_q.cost;
						end else if (free_hit_q) begin
							sel_idx_q        <= free_idx_q;
							res_q.status     <= ST_NEW_ROUTE;
							res_q.route_cost <= req_q.has_gateway ? req_q.cost_in : 32'h0;
						end else begin
							res_q.status <= ST_TBL_FULL;
						end
					end
					RQ_DEL: begin
						if (exact_hit_q) begin
							res_q.status     <= ST_DELETED;
							res_q.route_cost <= exact_word_q.cost;
						end else begin
							res_q.status <= ST_NOT_FOUND;
						end
					end
					RQ_CLR: res_q.status <= ST_CLEARED;
					RQ_FWD, RQ_ORIG: begin
						sel_idx_q  <= lidx;
						sel_word_q <= lword;
						hop_i_q    <= rot_start;
						if (!lhit) begin
							res_q.status <= ST_NO_ROUTE;
						end else begin
							res_q.route_cost <= lword.cost;
							if (lword.direct) begin
								if (is_fwd && is_local) begin
									res_q.status <= ST_LOCAL;
								end else begin
									res_q.status        <= ST_DIRECT;
									res_q.next_hop_addr <= req_q.dest_addr;
								end
							end else if (is_fwd && ttl_low) begin
								res_q.status  <= ST_TTL_EXP;
								res_q.ttl_out <= 8'd0;
							end else begin
								res_q.status <= ST_GATEWAY;
								if (is_fwd)
									res_q.ttl_out <= req_q.ttl_in - 8'd1;
							end
						end
					end
					default: ;
				endcase
			end
			CMD_HOP_CHK: begin
				if (stat.hop_dup)
					res_q.status <= ST_DUPLICATE;
				else if (!stat.hop_free && stat.hop_last)
					res_q.status <= ST_HOPS_FULL;
				else if (!stat.hop_free)
					hop_i_q <= hop_i_q + 1'b1;
			end
			CMD_HOP_WR: begin
				res_q.status     <= ST_HOP_ADDED;
				res_q.route_cost <= req_q.cost_in;
			end
			CMD_NEW:  hop_i_q <= '0;
			CMD_INIT: hop_i_q <= hop_i_q + 1'b1;
			CMD_RR_CHK0: begin
				if (stat.rr_retry) begin
					hop_i_q <= '0;
				end else begin
					res_q.next_hop_addr <= h_rd.present ? h_rd.gw : 32'h0;
					res_q.out_port      <= h_rd.present ? h_rd.port : 4'h0;
					hop_i_q <= stat.hop_last ? '0 : hop_i_q + 1'b1;
				end
			end
			CMD_RR_CHK1: if (!h_rd.present) hop_i_q <= '0;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/ipv4_route_table_lpm_ecmp.sv @@
// IPv4 route table, longest-prefix match with round-robin next hops.
// One request at a time, each handled by a sequential scan of the entry RAM.
// A new request is taken while a result still waits in the output register.
// Reset clears control state, config and all route valid bits at once; RAMs and payload registers are not swept.
module ipv4_route_table_lpm_ecmp import ipv4rt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	logic  busy;

	assign pready    = 1'b1;
	assign req_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_LOOPBACK: cfg_q.loopback      <= pwdata;
				REG_LOCAL0:   cfg_q.local_addr[0] <= pwdata;
				REG_LOCAL1:   cfg_q.local_addr[1] <= pwdata;
				REG_LOCAL2:   cfg_q.local_addr[2] <= pwdata;
				REG_LOCAL3:   cfg_q.local_addr[3] <= pwdata;
				REG_LOC_EN:   cfg_q.local_en      <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_LOOPBACK: prdata = cfg_q.loopback;
			REG_LOCAL0:   prdata = cfg_q.local_addr[0];
			REG_LOCAL1:   prdata = cfg_q.local_addr[1];
			REG_LOCAL2:   prdata = cfg_q.local_addr[2];
			REG_LOCAL3:   prdata = cfg_q.local_addr[3];
			REG_LOC_EN:   prdata = {28'h0, cfg_q.local_en};
			default:      prdata = 32'h0;
		endcase
	end

	ipv4rt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	ipv4rt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .req(req), .cfg(cfg_q),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

endmodule

@@ rtl/core/ipv4rt_checker.sv @@
// Port-level checks for the route table, bound to the top level.
// Depends on ipv4rt_pkg and ipv4_route_table_lpm_ecmp.
module ipv4rt_checker import ipv4rt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// an accepted request is followed by req_stall, the block being busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while block not busy afterwards");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_expired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_TTL_EXP |-> rsp.ttl_out == 8'd0
			&& rsp.next_hop_addr == 32'h0 && rsp.out_port == 4'h0)
		else $error("expired packet carries a next hop");

	a_noroute: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_NO_ROUTE || rsp.status == ST_CLEARED
			|| rsp.status == ST_TBL_FULL) |-> rsp.route_cost == 32'h0)
		else $error("cost reported without a route");

endmodule

bind ipv4_route_table_lpm_ecmp ipv4rt_checker u_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
